// ===== hdl/msgd_pkg.sv =====
// package for the message field deframer: section, kind and error codes,
// frame length limit, head/tail marks and the parser state type
// no dependencies
package msgd_pkg;

  localparam int unsigned MAX_FRAME_LEN = 1024;
  localparam int unsigned FC_W = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [FC_W-1:0] FC_MAX = FC_W'(MAX_FRAME_LEN);

  localparam int unsigned VALUE_W = 31;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  localparam logic [7:0] SPLIT_CHAR = 8'h0A;
  localparam logic [3:0] MARK_LEN = 4'd8;
  localparam logic [63:0] HEAD_MARK = "X-HEAD-X";
  localparam logic [63:0] TAIL_MARK = "Z-TAIL-Z";

  typedef enum logic [2:0] {
    SECT_HEAD     = 3'd0,
    SECT_TYPE     = 3'd1,
    SECT_SENDER   = 3'd2,
    SECT_RECEIVER = 3'd3,
    SECT_CONTENT  = 3'd4,
    SECT_DATETIME = 3'd5,
    SECT_TAIL     = 3'd6
  } sect_e;

  typedef enum logic [2:0] {
    KIND_TYPE     = 3'd0,
    KIND_SENDER   = 3'd1,
    KIND_RECEIVER = 3'd2,
    KIND_CONTENT  = 3'd3,
    KIND_DATETIME = 3'd4,
    KIND_ACCEPTED = 3'd5,
    KIND_REJECTED = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_BAD_HEAD = 2'd1,
    ERR_BAD_TAIL = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef struct packed {
    sect_e              section;
    logic [3:0]         match_pos;
    logic               mismatch;
    logic [VALUE_W-1:0] number_acc;
    logic               digits_stopped;
    logic [FC_W-1:0]    frame_count;
  } state_t;

  typedef struct packed {
    logic               has;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    err_e               error;
  } result_t;

  // byte at position pos of the head or tail mark, first character first
  function automatic logic [7:0] mark_char(input logic tail, input logic [2:0] pos);
    logic [5:0] lsb;
    lsb = {3'd7 - pos, 3'b000};
    mark_char = tail ? TAIL_MARK[lsb +: 8] : HEAD_MARK[lsb +: 8];
  endfunction

endpackage

// ===== hdl/msgd_in_if.sv =====
// input channel of the message field deframer: one stream byte per word
// no dependencies
interface msgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/msgd_out_if.sv =====
// output channel of the message field deframer: one parsed result per word
// no dependencies
interface msgd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [30:0] out_value;
  logic [1:0]  out_error;

  modport source (output valid, output out_kind, output out_value, output out_error,
                  input ready);
  modport sink (input valid, input out_kind, input out_value, input out_error,
                output ready);
endinterface

// ===== hdl/msgd_dec_acc.sv =====
// decimal accumulate step: acc*10 + digit with saturation
// depends on msgd_pkg
module msgd_dec_acc
  import msgd_pkg::*;
(
  input  logic [VALUE_W-1:0] acc_i,
  input  logic [7:0]         byte_i,
  output logic [VALUE_W-1:0] acc_o,
  output logic               digit_o
);

  localparam int unsigned SUM_W = VALUE_W + 4;

  logic [SUM_W-1:0] sum;
  logic [3:0]       digit;

  assign digit_o = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign digit   = 4'(byte_i - 8'h30);

  // times ten as two shifts
  assign sum = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + SUM_W'(digit);

  assign acc_o = (sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];

endmodule

// ===== hdl/msgd_step.sv =====
// per-byte parser step: next parser state and the optional result word
// depends on msgd_pkg and msgd_dec_acc
module msgd_step
  import msgd_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [VALUE_W-1:0] acc_nxt;
  logic               is_digit;
  logic               is_nl;
  logic               mark_hit;
  logic               line_ok;

  msgd_dec_acc u_dec (
    .acc_i   (state_i.number_acc),
    .byte_i  (byte_i),
    .acc_o   (acc_nxt),
    .digit_o (is_digit)
  );

  assign is_nl    = (byte_i == SPLIT_CHAR);
  assign mark_hit = (mark_char(state_i.section == SECT_TAIL, state_i.match_pos[2:0]) == byte_i);
  assign line_ok  = !state_i.mismatch && (state_i.match_pos == MARK_LEN);

  always_comb begin
    state_o        = state_i;
    result_o.has   = 1'b0;
    result_o.kind  = KIND_TYPE;
    result_o.value = '0;
    result_o.error = ERR_OK;

    if (state_i.frame_count >= FC_MAX) begin
      state_o        = '0;
      result_o.has   = 1'b1;
      result_o.kind  = KIND_REJECTED;
      result_o.error = ERR_TOO_LONG;
    end else begin
      state_o.frame_count = state_i.frame_count + FC_W'(1);
      case (state_i.section)
        SECT_TYPE, SECT_SENDER, SECT_RECEIVER, SECT_DATETIME: begin
          if (is_nl) begin
            result_o.has   = 1'b1;
            result_o.kind  = (state_i.section == SECT_DATETIME) ? KIND_DATETIME :
                             kind_e'(3'(state_i.section) - 3'd1);
            result_o.value = state_i.number_acc;
            state_o.number_acc     = '0;
            state_o.digits_stopped = 1'b0;
            state_o.section        = sect_e'(3'(state_i.section) + 3'd1);
          end else if (!state_i.digits_stopped && is_digit) begin
            state_o.number_acc = acc_nxt;
          end else begin
            state_o.digits_stopped = 1'b1;
          end
        end
        SECT_CONTENT: begin
          if (is_nl) begin
            state_o.section = SECT_DATETIME;
          end else begin
            result_o.has   = 1'b1;
            result_o.kind  = KIND_CONTENT;
            result_o.value = VALUE_W'(byte_i);
          end
        end
        SECT_TAIL: begin
          if (is_nl) begin
            state_o        = '0;
            result_o.has   = 1'b1;
            result_o.kind  = line_ok ? KIND_ACCEPTED : KIND_REJECTED;
            result_o.error = line_ok ? ERR_OK : ERR_BAD_TAIL;
          end else if (state_i.match_pos >= MARK_LEN) begin
            state_o.mismatch = 1'b1;
          end else begin
            state_o.mismatch  = state_i.mismatch | !mark_hit;
            state_o.match_pos = state_i.match_pos + 4'd1;
          end
        end
        default: begin
          // head line, also the unused section code
          if (is_nl) begin
            if (line_ok) begin
              state_o.section        = SECT_TYPE;
              state_o.match_pos      = '0;
              state_o.mismatch       = 1'b0;
              state_o.number_acc     = '0;
              state_o.digits_stopped = 1'b0;
            end else begin
              state_o        = '0;
              result_o.has   = 1'b1;
              result_o.kind  = KIND_REJECTED;
              result_o.error = ERR_BAD_HEAD;
            end
          end else if (state_i.match_pos >= MARK_LEN) begin
            state_o.mismatch = 1'b1;
          end else begin
            state_o.mismatch  = state_i.mismatch | !mark_hit;
            state_o.match_pos = state_i.match_pos + 4'd1;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/message_field_deframer.sv =====
// Message field deframer: takes one byte of a framed stream per cycle while
// the output does not stall, and gives at most one result word per byte
// (numeric field values, content bytes, frame accept or reject). A byte is
// registered on acceptance and parsed from that register by one decimal
// multiply-by-ten add and mark compare; its result is loaded into the output
// register when that register is empty or being taken, else the byte waits;
// the sustained rate is one byte per cycle without output stalls.
// Bytes that give no result pass even while a result waits at the output.
// Depends on msgd_pkg, msgd_in_if, msgd_out_if, msgd_step and msgd_dec_acc.
module message_field_deframer
  import msgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  msgd_in_if.sink     in_i,
  msgd_out_if.source  out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  state_t     state_q;
  state_t     state_d;
  result_t    result;
  logic       fire;
  logic       in_ready;

  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [VALUE_W-1:0] out_value_q;
  err_e               out_error_q;

  msgd_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // a byte without result never waits for the output register
  assign fire     = in_valid_q && (!result.has || !out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
      if (fire && result.has) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_byte_q <= in_i.in_byte;
    end
    if (fire && result.has) begin
      out_kind_q  <= result.kind;
      out_value_q <= result.value;
      out_error_q <= result.error;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_kind  = 3'(out_kind_q);
  assign out_o.out_value = out_value_q;
  assign out_o.out_error = 2'(out_error_q);

endmodule
